[sv/msd_pkg.sv]
// Shared types, constants and segment lookup for the seven-segment scan driver.
`timescale 1ns / 1ps
`default_nettype none

package msd_pkg;

  // Default number of scanned digits
  localparam int DIGIT_COUNT_DEF = 4;

  // Field widths
  localparam int VALUE_W   = 14;
  localparam int DWELL_W   = 16;
  localparam int DIGIT_W   = 4;
  localparam int ENABLE_W  = 4;
  localparam int SEG_W     = 8;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  // Item kinds carried on tuser
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Register index of dwell_ticks (index is paddr[2])
  localparam logic REG_DWELL = 1'b0;

  localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd5;
  localparam logic [SEG_W-1:0]   SEG_BLANK   = 8'hff;

  // Drive state shown for one transaction
  typedef struct packed {
    logic [ENABLE_W-1:0] digit_enable;
    logic [SEG_W-1:0]    segments;
  } msd_drive_t;

  // Active-low pattern of one decimal digit, blank for codes above nine
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] p;
    case (d)
      4'd0:    p = 8'hc0;
      4'd1:    p = 8'hf9;
      4'd2:    p = 8'ha4;
      4'd3:    p = 8'hb0;
      4'd4:    p = 8'h99;
      4'd5:    p = 8'h92;
      4'd6:    p = 8'h82;
      4'd7:    p = 8'hf8;
      4'd8:    p = 8'h80;
      4'd9:    p = 8'h90;
      default: p = SEG_BLANK;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[sv/msd_digit_split.sv]
// Decimal split of a 14-bit value into digits, units first, by reciprocal multiplies.
`timescale 1ns / 1ps
`default_nettype none

module msd_digit_split import msd_pkg::*; #(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  wire logic [VALUE_W-1:0] value,
  output logic [DIGIT_W-1:0]      digits [DIGIT_COUNT]
);

  // Quotients: v/10, v/100, v/1000 (exact for all 14-bit values)
  logic [29:0] prod1;
  logic [26:0] prod2;
  logic [28:0] prod3;
  logic [10:0] q1;
  logic [7:0]  q2;
  logic [4:0]  q3;

  assign prod1 = {16'd0, value} * 30'd52429;
  assign prod2 = {13'd0, value} * 27'd5243;
  assign prod3 = {15'd0, value} * 29'd16778;
  assign q1 = prod1[29:19];
  assign q2 = prod2[26:19];
  assign q3 = prod3[28:24];

  // Remainders give the digits
  logic [VALUE_W-1:0] t0;
  logic [10:0]        t1;
  logic [7:0]         t2;
  logic [VALUE_W-1:0] r0;
  logic [10:0]        r1;
  logic [7:0]         r2;
  logic [4:0]         r3;
  logic [DIGIT_W-1:0] all_d [8];

  assign t0 = 14'({3'd0, q1} * 14'd10);
  assign t1 = 11'({3'd0, q2} * 11'd10);
  assign t2 = 8'({3'd0, q3} * 8'd10);
  assign r0 = value - t0;
  assign r1 = q1 - t1;
  assign r2 = q2 - t2;
  // q3 is at most 16, one conditional subtract folds it
  assign r3 = (q3 >= 5'd10) ? (q3 - 5'd10) : q3;

  always_comb begin
    all_d[0] = r0[DIGIT_W-1:0];
    all_d[1] = r1[DIGIT_W-1:0];
    all_d[2] = r2[DIGIT_W-1:0];
    all_d[3] = r3[DIGIT_W-1:0];
    // ten-thousands digit is 0 or 1 for a 14-bit value
    all_d[4] = (value >= 14'd10000) ? 4'd1 : 4'd0;
    all_d[5] = '0;
    all_d[6] = '0;
    all_d[7] = '0;
  end

  always_comb begin
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      digits[k] = all_d[k];
    end
  end

endmodule

`default_nettype wire

[sv/msd_scan.sv]
// Digit store, scan position, dwell counter and blank phase, plus drive decode.
`timescale 1ns / 1ps
`default_nettype none

module msd_scan import msd_pkg::*; #(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire logic               action,
  input  wire logic [DIGIT_W-1:0] digits_new [DIGIT_COUNT],
  input  wire logic [DWELL_W-1:0] dwell_ticks,
  output msd_drive_t              drive
);

  localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGIT_COUNT - 1);

  logic [DIGIT_W-1:0] store_r [DIGIT_COUNT];
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [DWELL_W-1:0] dwell_r, dwell_nxt;
  logic               blank_r, blank_nxt;

  // Drive decode; a load shows its new digits at once
  logic [POS_W-1:0]   idx;
  logic [DIGIT_W-1:0] shown;

  assign idx   = POS_LAST - pos_r;
  assign shown = (action == ACT_LOAD) ? digits_new[idx] : store_r[idx];

  always_comb begin
    drive.digit_enable = '0;
    for (int i = 0; i < ENABLE_W; i++) begin
      if (i < DIGIT_COUNT) begin
        drive.digit_enable[i] = (pos_r == POS_W'(i));
      end
    end
    drive.segments = blank_r ? SEG_BLANK : seg_pattern(shown);
  end

  // Scan advance on a tick
  logic [DWELL_W-1:0] limit;
  logic [DWELL_W:0]   dwell_inc;

  assign limit     = (dwell_ticks == '0) ? DWELL_W'(1) : dwell_ticks;
  assign dwell_inc = {1'b0, dwell_r} + 1'b1;

  always_comb begin
    pos_nxt   = pos_r;
    dwell_nxt = dwell_r;
    blank_nxt = blank_r;
    if (fire && action == ACT_TICK) begin
      if (blank_r) begin
        blank_nxt = 1'b0;
        dwell_nxt = '0;
        pos_nxt   = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
      end else if (dwell_inc >= {1'b0, limit}) begin
        dwell_nxt = '0;
        blank_nxt = 1'b1;
      end else begin
        dwell_nxt = dwell_inc[DWELL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      dwell_r <= '0;
      blank_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      dwell_r <= dwell_nxt;
      blank_r <= blank_nxt;
    end
  end

  // Digit store, cleared by reset, written on a load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        store_r[k] <= '0;
      end
    end else if (fire && action == ACT_LOAD) begin
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        store_r[k] <= digits_new[k];
      end
    end
  end

  // Checks
  a_blank_no_dwell: assert property (@(posedge clk) disable iff (!rst_n)
    blank_r |-> dwell_r == '0)
    else $error("dwell count not cleared in blank phase");

  a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(drive.digit_enable))
    else $error("more than one digit line enabled");

  a_blank_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    fire && action == ACT_TICK && blank_r |=> !blank_r)
    else $error("blank phase lasted more than one tick");

  a_load_holds_scan: assert property (@(posedge clk) disable iff (!rst_n)
    fire && action == ACT_LOAD |=> $stable(pos_r) && $stable(blank_r))
    else $error("load transaction moved the scan");

endmodule

`default_nettype wire

[sv/msd_cfg.sv]
// APB-style register file holding dwell_ticks.
`timescale 1ns / 1ps
`default_nettype none

module msd_cfg import msd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready,
  output logic [DWELL_W-1:0]     dwell_ticks
);

  logic [DWELL_W-1:0] dwell_r;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register write, decoded on the word index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_r <= DWELL_RESET;
    end else if (wr_en && paddr[2] == REG_DWELL) begin
      dwell_r <= pwdata[DWELL_W-1:0];
    end
  end

  // Readback
  always_comb begin
    unique case (paddr[2])
      REG_DWELL: prdata = {{(CFG_DW-DWELL_W){1'b0}}, dwell_r};
      default:   prdata = '0;
    endcase
  end

  assign dwell_ticks = dwell_r;

endmodule

`default_nettype wire

[sv/multiplexed_seven_segment_driver_core.sv]
// Top level of the multiplexed seven-segment scan driver.
// Each transaction is either a load (tuser 0, new value in tdata) or a time
// tick (tuser 1) and returns one result: the one-hot digit line and the
// active-low segment byte driven during it. The block takes one transaction
// per clock cycle unless out_tready stalls it, via the input register and
// the result register, with the decimal split and scan update in between.
// A load shows its new digits at once and leaves the scan alone; a tick
// shows the present state, then advances: each digit is lit for dwell_ticks
// ticks, then blanked for one tick. dwell_ticks sits at byte address 0.
`timescale 1ns / 1ps
`default_nettype none

module multiplexed_seven_segment_driver_core import msd_pkg::*; #(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [15:0]       in_tdata,   // [13:0] value, [15:14] zero
  input  wire logic [0:0]        in_tuser,   // [0] action
  // result channel
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [15:0]            out_tdata,  // [3:0] digit_enable, [11:4] segments
  // configuration port
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  logic [DWELL_W-1:0] dwell_ticks;

  msd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .dwell_ticks (dwell_ticks)
  );

  // Input register stage
  logic               s1_valid_r;
  logic               s1_action_r;
  logic [VALUE_W-1:0] s1_value_r;
  logic               out_valid_r;
  msd_drive_t         out_drive_r;
  logic               advance;
  logic               fire;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_action_r <= in_tuser[0];
      s1_value_r  <= in_tdata[VALUE_W-1:0];
    end
  end

  // Decimal split and scan state
  logic [DIGIT_W-1:0] digits_new [DIGIT_COUNT];
  msd_drive_t         drive;

  msd_digit_split #(.DIGIT_COUNT(DIGIT_COUNT)) u_split (
    .value  (s1_value_r),
    .digits (digits_new)
  );

  msd_scan #(.DIGIT_COUNT(DIGIT_COUNT)) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .action      (s1_action_r),
    .digits_new  (digits_new),
    .dwell_ticks (dwell_ticks),
    .drive       (drive)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_drive_r <= drive;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_drive_r.segments, out_drive_r.digit_enable};

  // Checks
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("staged transaction lost while result stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed transaction produced no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with empty input stage");

endmodule

`default_nettype wire

[tb/multiplexed_seven_segment_driver_core_tb.sv]
// Self-checking testbench for the multiplexed seven-segment scan driver core.
`timescale 1ns / 1ps

module multiplexed_seven_segment_driver_core_tb;
  import msd_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 12;
  localparam int PIPE_LATENCY = 2;
  localparam int MAX_GAP      = 8;
  localparam int LONG_HOLD    = 150;
  localparam int MAX_PRINTS   = 40;
  localparam logic [CFG_AW-1:0] DWELL_ADDR = CFG_AW'({REG_DWELL, 2'b00});

  // Active-low glyphs for decimal digits 0..9
  localparam logic [SEG_W-1:0] GLYPH [10] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
  };

  logic clk;
  logic rst_n;

  logic                in_tvalid;
  logic                in_tready;
  logic [15:0]         in_tdata;   // [13:0] value, [15:14] zero
  logic [0:0]          in_tuser;   // [0] action
  logic                out_tvalid;
  logic                out_tready;
  logic [15:0]         out_tdata;  // [3:0] digit_enable, [11:4] segments, [15:12] zero
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  multiplexed_seven_segment_driver_core #(
    .DIGIT_COUNT(DIGIT_COUNT_DEF)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Clock
  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Shadow of the display state
  logic [DIGIT_W-1:0] shadow_digits [DIGIT_COUNT_DEF];  // entry 0 = units
  logic [1:0]         shadow_scan;
  int                 shadow_lit;
  logic               shadow_blank;
  logic [DWELL_W-1:0] shadow_dwell;

  msd_drive_t pending_drives [$];
  int         mismatch_count = 0;
  bit         gaps_on = 1'b0;
  int         hold_orders = 0;

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("MISMATCH @%0t: %s", $time, what);
  endtask

  function automatic int draw_gap();
    return gaps_on ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  // Drive state currently shown by the shadow
  function automatic msd_drive_t shown_drive();
    msd_drive_t d;
    logic [DIGIT_W-1:0] dig;
    dig = shadow_digits[DIGIT_COUNT_DEF - 1 - int'(shadow_scan)];
    d.digit_enable = ENABLE_W'(1) << shadow_scan;
    d.segments     = (shadow_blank || dig > 4'd9) ? SEG_BLANK : GLYPH[dig];
    return d;
  endfunction

  // Apply one accepted transaction to the shadow and queue its drive state
  task automatic predict_display(input logic act, input logic [VALUE_W-1:0] val);
    int rest;
    int limit;
    if (act == ACT_LOAD) begin
      rest = int'(val);
      for (int k = 0; k < DIGIT_COUNT_DEF; k++) begin
        shadow_digits[k] = DIGIT_W'(rest % 10);
        rest = rest / 10;
      end
      pending_drives.push_back(shown_drive());
    end else begin
      pending_drives.push_back(shown_drive());
      if (shadow_blank) begin
        shadow_blank = 1'b0;
        shadow_lit   = 0;
        shadow_scan  = shadow_scan + 2'd1;
      end else begin
        limit = (shadow_dwell == '0) ? 1 : int'(shadow_dwell);
        shadow_lit++;
        if (shadow_lit >= limit) begin
          shadow_lit   = 0;
          shadow_blank = 1'b1;
        end
      end
    end
  endtask

  // Send one transaction; returns right after the accepting edge
  task automatic send_item(input logic act, input logic [VALUE_W-1:0] val);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {2'b00, val};
    do @(posedge clk); while (!in_tready);
    predict_display(act, val);
  endtask

  task automatic send_tick();
    send_item(ACT_TICK, '0);
  endtask

  // Wait until every expected result is out and the pipeline has drained
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic check_dwell_readback(input logic [DWELL_W-1:0] want);
    logic [CFG_DW-1:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= DWELL_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got[DWELL_W-1:0] !== want)
      flag_mismatch($sformatf("dwell_ticks read %0h, want %0h", got[DWELL_W-1:0], want));
  endtask

  // Register write while idle, then read it back
  task automatic write_dwell(input logic [DWELL_W-1:0] ticks);
    settle_idle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= DWELL_ADDR;
    cfg_pwdata  <= CFG_DW'(ticks);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    shadow_dwell = ticks;
    check_dwell_readback(ticks);
  endtask

  // Result sink: random stalls, plus long hold-offs on request
  int sink_wait;
  int hold_left;
  int hold_served;

  always @(posedge clk) begin : sink_ctrl
    int gap;
    if (!rst_n) begin
      out_tready  <= 1'b0;
      sink_wait   <= 0;
      hold_left   <= 0;
      hold_served <= 0;
    end else if (hold_orders != hold_served) begin
      hold_served <= hold_served + 1;
      hold_left   <= LONG_HOLD;
      out_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= (hold_left == 1);
    end else if (out_tvalid && out_tready) begin
      gap = draw_gap();
      sink_wait  <= gap;
      out_tready <= (gap == 0);
    end else if (sink_wait > 0) begin
      sink_wait  <= sink_wait - 1;
      out_tready <= (sink_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin : result_check
    msd_drive_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_drives.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %04h", out_tdata));
      end else begin
        want = pending_drives.pop_front();
        if (out_tdata[3:0] !== want.digit_enable)
          flag_mismatch($sformatf("digit_enable %0h, want %0h",
                                  out_tdata[3:0], want.digit_enable));
        if (out_tdata[11:4] !== want.segments)
          flag_mismatch($sformatf("segments %02h, want %02h",
                                  out_tdata[11:4], want.segments));
      end
    end
  end

  // Tests

  task automatic test_reset_state();
    check_dwell_readback(DWELL_RESET);
    send_tick();
    send_tick();
  endtask

  task automatic test_directed_loads();
    send_item(ACT_LOAD, 14'd0);
    send_item(ACT_LOAD, 14'd16383);   // thousands digit wraps
    send_item(ACT_LOAD, 14'd9999);
    send_item(ACT_LOAD, 14'd10000);
    send_item(ACT_LOAD, 14'd8080);
    send_item(ACT_LOAD, 14'd1234);
  endtask

  // Shortest dwell: blank ticks and scan wrap come quickly
  task automatic test_blank_and_wrap();
    write_dwell(16'd1);
    for (int i = 0; i < 10; i++) begin
      if (i == 5) send_item(ACT_LOAD, 14'd5678);
      send_tick();
    end
  endtask

  // Zero dwell behaves like one
  task automatic test_dwell_zero();
    write_dwell(16'd0);
    repeat (3) send_tick();
  endtask

  task automatic test_dwell_max();
    write_dwell(16'hffff);
    repeat (3) send_tick();
  endtask

  task automatic send_random_item();
    logic [VALUE_W-1:0] val;
    if ($urandom_range(0, 5) == 0) begin
      if ($urandom_range(0, 7) == 0)
        val = VALUE_W'($urandom_range(10000, 16383));
      else
        val = VALUE_W'($urandom_range(0, 9999));
      send_item(ACT_LOAD, val);
    end else begin
      send_tick();
    end
  endtask

  // Random traffic over several dwell settings, idling toggled in stretches
  task automatic test_random_traffic();
    logic [DWELL_W-1:0] dwell_plan [8];
    dwell_plan = '{16'd1, 16'd2, 16'd3, 16'd5, DWELL_W'($urandom_range(1, 12)),
                   16'd0, DWELL_W'($urandom_range(13, 40)), 16'hffff};
    foreach (dwell_plan[p]) begin
      write_dwell(dwell_plan[p]);
      for (int i = 0; i < 190; i++) begin
        if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        send_random_item();
      end
    end
  endtask

  // Sink holds off for a long stretch while the source keeps offering
  task automatic test_backpressure();
    write_dwell(16'd2);
    gaps_on = 1'b0;
    hold_orders++;
    repeat (60) send_random_item();
    gaps_on = 1'b1;
  endtask

  initial begin
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= ACT_TICK;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;
    for (int k = 0; k < DIGIT_COUNT_DEF; k++) shadow_digits[k] = '0;
    shadow_scan  = '0;
    shadow_lit   = 0;
    shadow_blank = 1'b0;
    shadow_dwell = DWELL_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed_loads();
    test_blank_and_wrap();
    test_dwell_zero();
    test_dwell_max();
    test_random_traffic();
    test_backpressure();

    settle_idle();
    repeat (4 * PIPE_LATENCY) @(posedge clk);
    if (mismatch_count == 0 && pending_drives.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("timeout, %0d results still expected", pending_drives.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
